FILE: rtl/plc_pkg.sv
`timescale 1ns / 1ps
// plc_pkg: shared codes and controller/datapath interface structs for the
// positional list core. No dependencies.
package plc_pkg;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_POS   = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;         // latch the input word
    logic init;         // set up the entry pointers
    logic rd_prev;      // read entry at ptr-1
    logic rd_cur;       // read entry at ptr
    logic rd_next;      // read entry at ptr+1
    logic wr_value;     // write the new value at ptr
    logic wr_shift;     // write the read data at ptr
    logic ptr_dec;
    logic ptr_inc;
    logic cap_removed;  // keep the read data as the removed value
    logic cnt_inc;
    logic cnt_dec;
    logic emit;         // present a result word
    logic ok;           // result is a success
  } plc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_del;
    logic reject;
    logic at_idx;       // insert pointer reached the target slot
    logic last;         // delete pointer is at the last entry
  } plc_sts_t;

endpackage

FILE: rtl/plc_ctrl.sv
`timescale 1ns / 1ps
// plc_ctrl: sequencing state machine of the positional list core.
// Depends on plc_pkg.
module plc_ctrl import plc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  plc_sts_t sts_i,
  output plc_cmd_t cmd_o,
  output logic     busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_INS_CHK,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_CAP,
    S_DEL_CHK,
    S_DEL_WR
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    busy_d  = busy_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECIDE;
          busy_d     = 1'b1;
        end
      end
      S_DECIDE: begin
        if (sts_i.reject) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
          busy_d     = 1'b0;
        end else begin
          cmd_o.init = 1'b1;
          state_d    = sts_i.is_del ? S_DEL_RD : S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        if (sts_i.at_idx) begin
          cmd_o.wr_value = 1'b1;
          cmd_o.cnt_inc  = 1'b1;
          cmd_o.emit     = 1'b1;
          cmd_o.ok       = 1'b1;
          state_d        = S_IDLE;
          busy_d         = 1'b0;
        end else begin
          cmd_o.rd_prev = 1'b1;
          state_d       = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.ptr_dec  = 1'b1;
        state_d        = S_INS_CHK;
      end
      S_DEL_RD: begin
        cmd_o.rd_cur = 1'b1;
        state_d      = S_DEL_CAP;
      end
      S_DEL_CAP: begin
        cmd_o.cap_removed = 1'b1;
        state_d           = S_DEL_CHK;
      end
      S_DEL_CHK: begin
        if (sts_i.last) begin
          cmd_o.cnt_dec = 1'b1;
          cmd_o.emit    = 1'b1;
          cmd_o.ok      = 1'b1;
          state_d       = S_IDLE;
          busy_d        = 1'b0;
        end else begin
          cmd_o.rd_next = 1'b1;
          state_d       = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.ptr_inc  = 1'b1;
        state_d        = S_DEL_CHK;
      end
      default: begin
        state_d = S_IDLE;
        busy_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
    end
  end

  assign busy = busy_q;

`ifndef SYNTHESIS
  a_accept_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == S_DECIDE))
    else $error("accepted word did not enter decide");
  a_busy_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q == (state_q != S_IDLE))
    else $error("busy out of step with state");
  a_emit_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> !cmd_o.emit)
    else $error("two results for one word");
`endif

endmodule

FILE: rtl/plc_dpath.sv
`timescale 1ns / 1ps
// plc_dpath: entry memory, count, pointers and result registers of the
// positional list core. Depends on plc_pkg.
module plc_dpath import plc_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  plc_cmd_t           cmd_i,
  output plc_sts_t           sts_o,
  input  logic               op_i,
  input  logic [7:0]         position_i,
  input  logic signed [31:0] value_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [4:0]         count_o,
  output logic signed [31:0] removed_value_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > 9) ? CW : 9;

  logic [31:0]   mem [CAPACITY];
  logic [31:0]   rdata_q;

  logic          op_q;
  logic [7:0]    pos_q;
  logic [31:0]   val_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] ptr_q, idx_q;
  logic [31:0]   rem_q;

  logic          done_q;
  logic [1:0]    status_q;
  logic [4:0]    count_q;
  logic [31:0]   removed_q;

  logic [XW-1:0] pos_x, cnt_x, pm1_x;
  logic          reject;
  logic [1:0]    rej_code;
  logic [AW-1:0] raddr;
  logic          re, we;
  logic [31:0]   wdata;

  assign pos_x = XW'(pos_q);
  assign cnt_x = XW'(cnt_q);
  assign pm1_x = pos_x - XW'(1);

  always_comb begin
    reject   = 1'b0;
    rej_code = ST_OK;
    if (op_q == OP_INSERT) begin
      if (pos_q == 8'd0) begin
        reject   = 1'b1;
        rej_code = ST_POS;
      end else if (cnt_x >= XW'(CAPACITY)) begin
        reject   = 1'b1;
        rej_code = ST_FULL;
      end
    end else begin
      if (cnt_q == '0) begin
        reject   = 1'b1;
        rej_code = ST_EMPTY;
      end else if (pos_q == 8'd0 || pos_x > cnt_x) begin
        reject   = 1'b1;
        rej_code = ST_POS;
      end
    end
  end

  assign sts_o.is_del = (op_q == OP_DELETE);
  assign sts_o.reject = reject;
  assign sts_o.at_idx = (ptr_q == idx_q);
  assign sts_o.last   = ((CW'(ptr_q) + CW'(1)) == cnt_q);

  always_comb begin
    raddr = ptr_q;
    if (cmd_i.rd_prev) raddr = ptr_q - AW'(1);
    if (cmd_i.rd_next) raddr = ptr_q + AW'(1);
  end

  assign re    = cmd_i.rd_prev | cmd_i.rd_cur | cmd_i.rd_next;
  assign we    = cmd_i.wr_value | cmd_i.wr_shift;
  assign wdata = cmd_i.wr_value ? val_q : rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[ptr_q] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) cnt_d = cnt_q + CW'(1);
    if (cmd_i.cnt_dec) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      pos_q <= position_i;
      val_q <= value_i;
    end
    if (cmd_i.init) begin
      if (op_q == OP_INSERT) begin
        ptr_q <= AW'(cnt_q);
        idx_q <= (pm1_x > cnt_x) ? AW'(cnt_q) : AW'(pm1_x);
      end else begin
        ptr_q <= AW'(pm1_x);
        idx_q <= AW'(pm1_x);
      end
    end else if (cmd_i.ptr_dec) begin
      ptr_q <= ptr_q - AW'(1);
    end else if (cmd_i.ptr_inc) begin
      ptr_q <= ptr_q + AW'(1);
    end
    if (cmd_i.cap_removed) rem_q <= rdata_q;
    if (cmd_i.emit) begin
      status_q  <= cmd_i.ok ? ST_OK : rej_code;
      count_q   <= 5'(cnt_d);
      removed_q <= (cmd_i.ok && op_q == OP_DELETE) ? rem_q : 32'd0;
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign count_o         = count_q;
  assign removed_value_o = removed_q;

`ifndef SYNTHESIS
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |->
      (cnt_q == $past(cnt_q) + CW'(1) || cnt_q == $past(cnt_q) - CW'(1)))
    else $error("entry count moved by more than one");
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |-> (cnt_x < XW'(CAPACITY)))
    else $error("insert into full list");
  a_ins_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && op_q == OP_INSERT) |-> (removed_q == 32'd0))
    else $error("insert reported a removed value");
`endif

endmodule

FILE: rtl/positional_list_insert_delete_core.sv
`timescale 1ns / 1ps
// positional_list_insert_delete_core: top level of the positional list core.
// Depends on plc_pkg, plc_ctrl and plc_dpath.
//
// Ordered list of up to CAPACITY signed 32-bit entries edited by insert or
// delete at a 1-based position. A word is taken when start is high and busy
// is low; its single result appears on status_o, count_o and removed_value_o
// for exactly one cycle with done_o high and must be captured then, as the
// core cannot be stalled. Entries live in a single-port memory and are moved
// one at a time, each read from its old slot and then written to its new one.
// The memory needs no clearing after reset; the entry count resets to zero.
module positional_list_insert_delete_core import plc_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               op_i,
  input  logic [7:0]         position_i,
  input  logic signed [31:0] value_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [4:0]         count_o,
  output logic signed [31:0] removed_value_o
);

  plc_cmd_t cmd;
  plc_sts_t sts;

  plc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  plc_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .op_i            (op_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .count_o         (count_o),
    .removed_value_o (removed_value_o)
  );

endmodule
